// ===== src/crsf_rx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rx_pkg
// shared types, constants and the crc-8 step of the rc frame receiver
// ----------------------------------------------------------------------------
package crsf_rx_pkg;

    // default sizes handed to the top level
    localparam int MAX_FRAME_LEN_DEF = 64;
    localparam int NUM_CHANNELS_DEF  = 16;

    // framing
    localparam logic [7:0] SYNC_CODE   = 8'hC8;
    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam int         MIN_LEN     = 2;
    localparam int         CH_BITS     = 11;

    // channel scaling: (v - 172) * 1000 / 1639 + 1000
    localparam int          SCALE_OFFSET = 172;
    localparam int          SCALE_MUL    = 1000;
    localparam int          SCALE_DIV    = 1639;
    localparam int          SCALE_BASE   = 1000;
    localparam int          RECIP_SHIFT  = 32;
    localparam logic [21:0] RECIP_MUL    =
        22'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

    // failsafe counter
    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    // register reset values
    localparam logic [15:0] TIMEOUT_RST   = 16'd100;
    localparam logic [7:0]  RC_TYPE_RST   = 8'd22;
    localparam logic [7:0]  LINK_TYPE_RST = 8'd20;

    // register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_RC_TYPE   = 2'd1,
        CFG_LINK_TYPE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] timeout;
        logic [7:0]  rc_type;
        logic [7:0]  link_type;
    } cfg_t;

    // work passed from parser to emitter
    typedef enum logic [1:0] {
        EV_TICK = 2'd0,
        EV_RC   = 2'd1,
        EV_LINK = 2'd2
    } event_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_RSSI    = 2'd1,
        KIND_LOST    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PS_SYNC,
        PS_LEN,
        PS_TYPE,
        PS_BODY,
        PS_CRC
    } parse_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_TICK,
        BK_CH_LOAD,
        BK_CH_MERGE,
        BK_CH_MUL,
        BK_CH_OUT,
        BK_LINK_A,
        BK_LINK_B,
        BK_LINK_C,
        BK_LINK_OUT
    } back_state_t;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/crsf_rx_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module crsf_rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       clk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]           wr_data,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/crsf_rx_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rx_queue
// two-entry event queue between parser and emitter
// ----------------------------------------------------------------------------
module crsf_rx_queue
    import crsf_rx_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     push,
    input  event_t  push_event,
    input  wire     pop,
    output event_t  pop_event,
    output logic    full,
    output logic    empty
);

    event_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign pop_event = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_event;
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("event queue overflow");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("event queue underflow");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("event queue count out of range");

endmodule
`default_nettype wire

// ===== src/crsf_rx_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rx_front
// byte framing, running crc, frame store writes and event classification
// ----------------------------------------------------------------------------
module crsf_rx_front
    import crsf_rx_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              command,
    input  wire  [7:0]                       rx_byte,
    input  cfg_t                             cfg,
    input  wire                              q_full,
    output logic                             q_push,
    output event_t                           q_event,
    input  wire                              frame_done,
    output logic                             st_wr_en,
    output logic [$clog2(MAX_FRAME_LEN)-1:0] st_wr_addr,
    output logic [7:0]                       st_wr_data,
    output logic [MAX_FRAME_LEN-1:0]         st_valid
);

    localparam int AW = $clog2(MAX_FRAME_LEN);
    localparam int LW = $clog2(MAX_FRAME_LEN + 1);

    parse_state_t             state_reg, state_next;
    logic [LW-1:0]            body_length_reg, body_length_next;
    logic [LW-1:0]            body_index_reg, body_index_next;
    logic [7:0]               frame_kind_reg, frame_kind_next;
    logic [7:0]               crc_reg, crc_next;
    logic [MAX_FRAME_LEN-1:0] valid_reg, valid_next;
    logic [1:0]               pend_reg, pend_next;

    logic          writes_store;
    logic          accept;
    logic          byte_in;
    logic          bad_len;
    logic [LW-1:0] index_inc;
    logic          push_frame;

    // store may not change while an earlier frame is still being emitted
    assign writes_store = (state_reg == PS_TYPE) || (state_reg == PS_BODY);
    assign in_stall     = q_full || (!command && writes_store && (pend_reg != 2'd0));
    assign accept       = in_valid && !in_stall;
    assign byte_in      = accept && !command;
    assign bad_len      = ({1'b0, rx_byte} > 9'(MAX_FRAME_LEN)) || (rx_byte < 8'(MIN_LEN));
    assign index_inc    = LW'(body_index_reg + 1'b1);
    assign st_valid     = valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (byte_in)
        begin
            unique case (state_reg)
                PS_SYNC:
                begin
                    if (rx_byte == SYNC_CODE)
                    begin
                        state_next = PS_LEN;
                    end
                end
                PS_LEN:
                begin
                    state_next = bad_len ? PS_SYNC : PS_TYPE;
                end
                PS_TYPE:
                begin
                    state_next = (body_length_reg == '0) ? PS_CRC : PS_BODY;
                end
                PS_BODY:
                begin
                    if (index_inc > body_length_reg)
                    begin
                        state_next = PS_CRC;
                    end
                end
                PS_CRC:
                begin
                    state_next = PS_SYNC;
                end
                default:
                begin
                    state_next = PS_SYNC;
                end
            endcase
        end
    end

    // datapath and outputs
    always_comb
    begin
        body_length_next = body_length_reg;
        body_index_next  = body_index_reg;
        frame_kind_next  = frame_kind_reg;
        crc_next         = crc_reg;
        q_push           = 1'b0;
        q_event          = EV_TICK;
        st_wr_en         = 1'b0;
        st_wr_addr       = body_index_reg[AW-1:0];
        st_wr_data       = rx_byte;

        if (accept && command)
        begin
            q_push = 1'b1;
        end

        if (byte_in)
        begin
            unique case (state_reg)
                PS_LEN:
                begin
                    if (!bad_len)
                    begin
                        body_length_next = LW'(rx_byte - 8'(MIN_LEN));
                        body_index_next  = '0;
                    end
                end
                PS_TYPE:
                begin
                    frame_kind_next = rx_byte;
                    st_wr_en        = 1'b1;
                    st_wr_addr      = '0;
                    body_index_next = LW'(1);
                    crc_next        = crc8_step(8'h00, rx_byte);
                end
                PS_BODY:
                begin
                    st_wr_en        = 1'b1;
                    body_index_next = index_inc;
                    crc_next        = crc8_step(crc_reg, rx_byte);
                end
                PS_CRC:
                begin
                    if (crc_reg == rx_byte)
                    begin
                        if (frame_kind_reg == cfg.rc_type)
                        begin
                            q_push  = 1'b1;
                            q_event = EV_RC;
                        end
                        else if (frame_kind_reg == cfg.link_type)
                        begin
                            q_push  = 1'b1;
                            q_event = EV_LINK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        valid_next = valid_reg;
        if (st_wr_en)
        begin
            valid_next[st_wr_addr] = 1'b1;
        end

        push_frame = q_push && (q_event != EV_TICK);
        pend_next  = 2'(pend_reg + {1'b0, push_frame} - {1'b0, frame_done});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= PS_SYNC;
            body_length_reg <= '0;
            body_index_reg  <= '0;
            frame_kind_reg  <= '0;
            crc_reg         <= '0;
            valid_reg       <= '0;
            pend_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            body_length_reg <= body_length_next;
            body_index_reg  <= body_index_next;
            frame_kind_reg  <= frame_kind_next;
            crc_reg         <= crc_next;
            valid_reg       <= valid_next;
            pend_reg        <= pend_next;
        end
    end

    a_no_store_write_busy : assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> (pend_reg == 2'd0))
        else $error("frame store written while a frame is being emitted");

    a_index_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PS_BODY) |-> (body_index_reg <= body_length_reg))
        else $error("body index past frame length");

    a_pend_range : assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3 || $past(pend_reg) != 2'd0)
        else $error("pending frame count jumped");

endmodule
`default_nettype wire

// ===== src/crsf_rx_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rx_back
// event execution: channel unpack and scaling, link rssi, failsafe timer
// ----------------------------------------------------------------------------
module crsf_rx_back
    import crsf_rx_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  cfg_t                             cfg,
    input  wire                              q_empty,
    input  event_t                           q_event,
    output logic                             q_pop,
    output logic                             frame_done,
    output logic [$clog2(MAX_FRAME_LEN)-1:0] st_rd_addr,
    input  wire  [7:0]                       st_rd_data,
    input  wire  [MAX_FRAME_LEN-1:0]         st_valid,
    output logic                             out_valid,
    input  wire                              out_stall,
    output kind_t                            kind,
    output logic [3:0]                       channel_index,
    output logic [11:0]                      channel_value,
    output logic signed [8:0]                rssi_dbm,
    output logic                             signal_lost,
    output logic                             last
);

    localparam int AW = $clog2(MAX_FRAME_LEN);

    back_state_t  state_reg, state_next;
    logic [17:0]  acc_reg, acc_next;
    logic [4:0]   avail_reg, avail_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [3:0]   ch_reg, ch_next;
    logic         neg_reg, neg_next;
    logic [20:0]  p_reg, p_next;
    logic [10:0]  q_reg, q_next;
    logic [7:0]   a_reg, a_next;
    logic [7:0]   b_reg, b_next;
    logic [16:0]  ticks_reg, ticks_next;
    logic         lost_reg, lost_next;
    logic         valid_q_reg;

    logic         out_valid_reg, out_valid_next;
    kind_t        kind_reg, kind_next;
    logic [3:0]   idx_reg, idx_next;
    logic [11:0]  value_reg, value_next;
    logic [8:0]   rssi_reg, rssi_next;
    logic         lost_out_reg, lost_out_next;
    logic         last_reg, last_next;

    logic         out_free;
    logic         load_out;
    logic [7:0]   byte_eff;
    logic [16:0]  tick_inc;
    logic         tick_lost;
    logic [10:0]  raw;
    logic         raw_neg;
    logic [10:0]  mag;
    logic [42:0]  prod;
    logic [7:0]   best;
    logic         ch_final;

    assign out_free  = !out_valid_reg || !out_stall;
    assign byte_eff  = valid_q_reg ? st_rd_data : 8'h00;
    assign tick_inc  = (ticks_reg == TICK_MAX) ? ticks_reg : 17'(ticks_reg + 1'b1);
    assign tick_lost = tick_inc > {1'b0, cfg.timeout};
    assign raw       = acc_reg[CH_BITS-1:0];
    assign raw_neg   = raw < 11'(SCALE_OFFSET);
    assign mag       = raw_neg ? 11'(11'(SCALE_OFFSET) - raw) : 11'(raw - 11'(SCALE_OFFSET));
    assign prod      = 43'(p_reg) * 43'(RECIP_MUL);
    assign best      = (a_reg < b_reg) ? a_reg : b_reg;
    assign ch_final  = (ch_reg == 4'(NUM_CHANNELS - 1));

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign channel_index = idx_reg;
    assign channel_value = value_reg;
    assign rssi_dbm      = rssi_reg;
    assign signal_lost   = lost_out_reg;
    assign last          = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_event)
                        EV_TICK: state_next = BK_TICK;
                        EV_RC:   state_next = BK_CH_LOAD;
                        EV_LINK: state_next = BK_LINK_A;
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_TICK:
            begin
                if (!tick_lost || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_CH_LOAD:
            begin
                state_next = (avail_reg < 5'(CH_BITS)) ? BK_CH_MERGE : BK_CH_MUL;
            end
            BK_CH_MERGE: state_next = BK_CH_LOAD;
            BK_CH_MUL:   state_next = BK_CH_OUT;
            BK_CH_OUT:
            begin
                if (out_free)
                begin
                    state_next = ch_final ? BK_IDLE : BK_CH_LOAD;
                end
            end
            BK_LINK_A:   state_next = BK_LINK_B;
            BK_LINK_B:   state_next = BK_LINK_C;
            BK_LINK_C:   state_next = BK_LINK_OUT;
            BK_LINK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        acc_next      = acc_reg;
        avail_next    = avail_reg;
        pos_next      = pos_reg;
        ch_next       = ch_reg;
        neg_next      = neg_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        ticks_next    = ticks_reg;
        lost_next     = lost_reg;
        q_pop         = 1'b0;
        frame_done    = 1'b0;
        st_rd_addr    = pos_reg;
        load_out      = 1'b0;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        value_next    = value_reg;
        rssi_next     = rssi_reg;
        lost_out_next = lost_out_reg;
        last_next     = last_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_event == EV_RC)
                    begin
                        // a good rc frame restarts the failsafe timer
                        acc_next   = '0;
                        avail_next = '0;
                        pos_next   = AW'(1);
                        ch_next    = '0;
                        lost_next  = 1'b0;
                        ticks_next = '0;
                    end
                end
            end
            BK_TICK:
            begin
                if (!tick_lost)
                begin
                    ticks_next = tick_inc;
                end
                else if (out_free)
                begin
                    ticks_next    = tick_inc;
                    lost_next     = 1'b1;
                    load_out      = 1'b1;
                    kind_next     = KIND_LOST;
                    idx_next      = '0;
                    value_next    = '0;
                    rssi_next     = '0;
                    lost_out_next = 1'b1;
                    last_next     = 1'b1;
                end
            end
            BK_CH_LOAD:
            begin
                if (avail_reg < 5'(CH_BITS))
                begin
                    pos_next = AW'(pos_reg + 1'b1);
                end
                else
                begin
                    neg_next   = raw_neg;
                    p_next     = 21'(mag) * 21'(SCALE_MUL);
                    acc_next   = acc_reg >> CH_BITS;
                    avail_next = 5'(avail_reg - 5'(CH_BITS));
                end
            end
            BK_CH_MERGE:
            begin
                acc_next   = acc_reg | (18'(byte_eff) << avail_reg);
                avail_next = 5'(avail_reg + 5'd8);
            end
            BK_CH_MUL:
            begin
                q_next = prod[RECIP_SHIFT+10:RECIP_SHIFT];
            end
            BK_CH_OUT:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    kind_next     = KIND_CHANNEL;
                    idx_next      = ch_reg;
                    value_next    = neg_reg ? 12'(12'(SCALE_BASE) - 12'(q_reg))
                                            : 12'(12'(SCALE_BASE) + 12'(q_reg));
                    rssi_next     = '0;
                    lost_out_next = lost_reg;
                    last_next     = ch_final;
                    if (ch_final)
                    begin
                        frame_done = 1'b1;
                    end
                    else
                    begin
                        ch_next = 4'(ch_reg + 1'b1);
                    end
                end
            end
            BK_LINK_A:
            begin
                st_rd_addr = AW'(1);
            end
            BK_LINK_B:
            begin
                st_rd_addr = AW'(2);
                a_next     = byte_eff;
            end
            BK_LINK_C:
            begin
                b_next = byte_eff;
            end
            BK_LINK_OUT:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    frame_done    = 1'b1;
                    kind_next     = KIND_RSSI;
                    idx_next      = '0;
                    value_next    = '0;
                    rssi_next     = 9'(9'd0 - {1'b0, best});
                    lost_out_next = lost_reg;
                    last_next     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ticks_reg     <= '0;
            lost_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            avail_reg     <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ticks_reg     <= ticks_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            avail_reg     <= avail_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        valid_q_reg  <= st_valid[st_rd_addr];
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        value_reg    <= value_next;
        rssi_reg     <= rssi_next;
        lost_out_reg <= lost_out_next;
        last_reg     <= last_next;
    end

    a_chan_not_lost : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_CHANNEL) |-> !lost_out_reg)
        else $error("channel result reports signal lost");

    a_lost_report : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_LOST) |-> (lost_out_reg && last_reg))
        else $error("lost report without lost flag or last mark");

    a_ch_range : assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= 4'(NUM_CHANNELS - 1))
        else $error("channel counter past channel count");

    a_avail_range : assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg <= 5'd18)
        else $error("bit accumulator overfilled");

endmodule
`default_nettype wire

// ===== src/crsf_rc_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_rc_frame_receiver
// rc link receiver: frame parser with crc-8, channel scaling and failsafe
// ----------------------------------------------------------------------------
// input: a byte or tick is taken while the event queue has room; a frame byte is also
//   held while an earlier frame is still being emitted from the frame store
// output: an rc frame yields NUM_CHANNELS (16 by default) channel results, the
//   emitter fetching store bytes and scaling each channel in turn; the event queue
//   lets the parser take new ticks while the emitter is busy
// reset: parser to sync hunt, timer cleared, lost flag set, store valid bits
//   cleared so the frame store reads as zeros, registers to defaults
// ----------------------------------------------------------------------------
module crsf_rc_frame_receiver
    import crsf_rx_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,

    // configuration write port
    input  wire                cfg_we,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_data,

    // input transactions: bytes and ticks
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                command,
    input  wire  [7:0]         rx_byte,

    // output transactions: results
    output logic               out_valid,
    input  wire                out_stall,
    output logic [1:0]         kind,
    output logic [3:0]         channel_index,
    output logic [11:0]        channel_value,
    output logic signed [8:0]  rssi_dbm,
    output logic               signal_lost,
    output logic               last
);

    localparam int AW = $clog2(MAX_FRAME_LEN);

    // configuration registers; the user writes them only while the block is idle, the block itself does not enforce it
    cfg_t cfg_reg, cfg_next;

    // front to back event queue
    logic   q_push;
    event_t q_push_event;
    logic   q_pop;
    event_t q_pop_event;
    logic   q_full;
    logic   q_empty;

    // frame store: front writes, back reads
    logic                     st_wr_en;
    logic [AW-1:0]            st_wr_addr;
    logic [7:0]               st_wr_data;
    logic [AW-1:0]            st_rd_addr;
    logic [7:0]               st_rd_data;
    logic [MAX_FRAME_LEN-1:0] st_valid;

    logic  frame_done;
    kind_t kind_out;

    assign kind = kind_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   cfg_next.timeout   = cfg_data;
                CFG_RC_TYPE:   cfg_next.rc_type   = cfg_data[7:0];
                CFG_LINK_TYPE: cfg_next.link_type = cfg_data[7:0];
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout   <= TIMEOUT_RST;
            cfg_reg.rc_type   <= RC_TYPE_RST;
            cfg_reg.link_type <= LINK_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: framing, running crc, store writes, classification into events
    crsf_rx_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .rx_byte    (rx_byte),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_event    (q_push_event),
        .frame_done (frame_done),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_valid   (st_valid)
    );

    // short queue decoupling the two sides
    crsf_rx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_event (q_push_event),
        .pop        (q_pop),
        .pop_event  (q_pop_event),
        .full       (q_full),
        .empty      (q_empty)
    );

    // frame store, entries not yet written read as zero via the valid bits
    crsf_rx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // back: channel unpack and scaling, link rssi, failsafe timer, output register
    crsf_rx_back #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_event       (q_pop_event),
        .q_pop         (q_pop),
        .frame_done    (frame_done),
        .st_rd_addr    (st_rd_addr),
        .st_rd_data    (st_rd_data),
        .st_valid      (st_valid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind_out),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .rssi_dbm      (rssi_dbm),
        .signal_lost   (signal_lost),
        .last          (last)
    );

endmodule
`default_nettype wire
